// ===== hw/rtl/smooth_wrr_server_assign_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef SMOOTH_WRR_SERVER_ASSIGN_MACROS_SVH
`define SMOOTH_WRR_SERVER_ASSIGN_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SWRR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swrr same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define SWRR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swrr next-cycle check failed");

`endif

// ===== hw/rtl/swrr_pkg.sv =====
package swrr_pkg;

  localparam int CLIENT_W        = 8;
  localparam int CLIENT_SPACE    = 1 << CLIENT_W;
  localparam int SERVER_W        = 3;
  localparam int LOAD_W          = 16;
  localparam int WEIGHT_W        = 7;
  localparam int NUM_WREGS       = 5;
  localparam int RW_W            = 11;
  localparam int RW_EXT_W        = 13;
  localparam int TOTAL_W         = 10;
  localparam int APB_ADDR_W      = 5;
  localparam int APB_DATA_W      = 32;
  localparam int DEF_NUM_CLIENTS = 256;
  localparam int DEF_NUM_SERVERS = 5;

  typedef logic [WEIGHT_W-1:0]        weight_t;
  typedef logic signed [RW_W-1:0]     rw_t;
  typedef logic signed [RW_EXT_W-1:0] rw_ext_t;
  typedef logic [LOAD_W-1:0]          load_t;
  typedef logic [SERVER_W-1:0]        server_t;
  typedef logic [CLIENT_W-1:0]        client_t;

  localparam weight_t WEIGHT_RESET [NUM_WREGS] = '{7'd40, 7'd20, 7'd30, 7'd70, 7'd40};

  localparam rw_ext_t RW_MAX = 13'sd1023;
  localparam rw_ext_t RW_MIN = -13'sd1024;

  // request kinds carried on the input tuser
  localparam logic REQ_REGISTER = 1'b0;
  localparam logic REQ_SERVICE  = 1'b1;

  typedef struct packed {
    logic    pick;    // this request runs the round robin
    logic    commit;  // the request leaves the work stage this cycle
    server_t server;  // stored mapping, used when no pick is made
  } pick_ctl_t;

  typedef struct packed {
    server_t winner;
    load_t   load;    // load of the selected server after this request
  } pick_res_t;

  typedef struct packed {
    logic    en;
    client_t client;
    server_t server;
  } map_wr_t;

  typedef struct packed {
    logic    hit;     // client in range and mapped
    server_t server;
  } map_rd_t;

  function automatic rw_t rw_sat(input rw_ext_t v);
    rw_ext_t c;
    c = v;
    if (v > RW_MAX) c = RW_MAX;
    if (v < RW_MIN) c = RW_MIN;
    return rw_t'(c[RW_W-1:0]);
  endfunction

  function automatic rw_t rw_add(input rw_t rw, input weight_t w);
    rw_ext_t a;
    rw_ext_t b;
    a = {{(RW_EXT_W-RW_W){rw[RW_W-1]}}, rw};
    b = $signed({{(RW_EXT_W-WEIGHT_W){1'b0}}, w});
    return rw_sat(a + b);
  endfunction

  function automatic rw_t rw_sub(input rw_t rw, input logic [TOTAL_W-1:0] t);
    rw_ext_t a;
    rw_ext_t b;
    a = {{(RW_EXT_W-RW_W){rw[RW_W-1]}}, rw};
    b = $signed({{(RW_EXT_W-TOTAL_W){1'b0}}, t});
    return rw_sat(a - b);
  endfunction

  function automatic load_t load_inc(input load_t c);
    return (c == '1) ? c : c + load_t'(1);
  endfunction

endpackage

// ===== hw/rtl/swrr_pick.sv =====
module swrr_pick import swrr_pkg::*; #(
  parameter int NUM_SERVERS = DEF_NUM_SERVERS
) (
  input  logic      clk,
  input  logic      rst,
  input  weight_t   weight [NUM_WREGS],
  input  pick_ctl_t ctl,
  output pick_res_t res
);

  rw_t                rw    [NUM_SERVERS];
  rw_t                grown [NUM_SERVERS];
  load_t              cnt   [NUM_SERVERS];
  logic [TOTAL_W-1:0] total;
  rw_t                lead_rw;
  server_t            best;
  rw_t                best_drop;
  load_t              win_cnt;
  load_t              win_cnt_next;
  load_t              lk_cnt;

  // grow every running weight, then keep the first largest
  always_comb begin
    total = '0;
    for (int i = 0; i < NUM_SERVERS; i++) begin
      total = total + TOTAL_W'(weight[i]);
      grown[i] = rw_add(rw[i], weight[i]);
    end
    best = '0;
    lead_rw = grown[0];
    for (int i = 1; i < NUM_SERVERS; i++) begin
      if (grown[i] > lead_rw) begin
        best = SERVER_W'(i);
        lead_rw = grown[i];
      end
    end
    best_drop = rw_sub(lead_rw, total);
  end

  always_comb begin
    win_cnt = '0;
    lk_cnt = '0;
    for (int i = 0; i < NUM_SERVERS; i++) begin
      if (best == SERVER_W'(i)) win_cnt = cnt[i];
      if (ctl.server == SERVER_W'(i)) lk_cnt = cnt[i];
    end
    win_cnt_next = load_inc(win_cnt);
  end

  assign res.winner = best;
  assign res.load   = ctl.pick ? win_cnt_next : lk_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SERVERS; i++) begin
        rw[i]  <= '0;
        cnt[i] <= '0;
      end
    end else if (ctl.commit && ctl.pick) begin
      for (int i = 0; i < NUM_SERVERS; i++) begin
        if (best == SERVER_W'(i)) begin
          rw[i]  <= best_drop;
          cnt[i] <= win_cnt_next;
        end else begin
          rw[i]  <= grown[i];
        end
      end
    end
  end

endmodule

// ===== hw/rtl/swrr_map.sv =====
module swrr_map import swrr_pkg::*; #(
  parameter int NUM_CLIENTS = DEF_NUM_CLIENTS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    rd_en,
  input  client_t rd_client,
  input  client_t lk_client,
  input  map_wr_t wr,
  output map_rd_t rd
);

  // only the first CLIENT_SPACE slots are reachable by an 8-bit index
  localparam int MAP_DEPTH = (NUM_CLIENTS < CLIENT_SPACE) ? NUM_CLIENTS : CLIENT_SPACE;
  localparam int AW        = $clog2(MAP_DEPTH);

  server_t              mem [MAP_DEPTH];
  logic [MAP_DEPTH-1:0] valid;
  server_t              rd_data;
  logic                 wr_ok;
  logic                 lk_in_range;
  logic                 fwd;

  assign wr_ok       = wr.en && ({24'b0, wr.client} < 32'(NUM_CLIENTS));
  assign lk_in_range = {24'b0, lk_client} < 32'(NUM_CLIENTS);
  // a write landing on the same edge as the read wins
  assign fwd         = wr_ok && (wr.client == rd_client);

  always_ff @(posedge clk) begin
    if (wr_ok) mem[wr.client[AW-1:0]] <= wr.server;
    if (rd_en) rd_data <= fwd ? wr.server : mem[rd_client[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_ok) begin
      valid[wr.client[AW-1:0]] <= 1'b1;
    end
  end

  assign rd.hit    = lk_in_range && valid[lk_client[AW-1:0]];
  assign rd.server = rd_data;

endmodule

// ===== hw/rtl/smooth_wrr_server_assign.sv =====
// Channel     | Signals                                   | Carries
// ------------+-------------------------------------------+----------------------------------
// request in  | s_tvalid s_tready s_tdata[7:0] s_tuser    | client_index; req_type on tuser
// result out  | m_tvalid m_tready m_tdata[23:0] m_tuser   | server_index, server_load;
//             |                                           | newly_picked on tuser
// config      | psel penable pwrite paddr pwdata prdata   | weight_0..weight_4 at 4*i
//
// One request per cycle sustained while results are taken; each passes the work stage
// and result register. The client map read is registered alongside the input register.
// Reset (rst, synchronous) clears running weights, load counts and all map valid bits
// at once, and loads the default weights; no clearing pass is needed.
// A stalled result holds the work stage; input ready drops only while both are full.
`include "smooth_wrr_server_assign_macros.svh"

module smooth_wrr_server_assign import swrr_pkg::*; #(
  parameter int NUM_CLIENTS = DEF_NUM_CLIENTS,
  parameter int NUM_SERVERS = DEF_NUM_SERVERS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] client_index
  input  logic                  s_tuser,   // [0] req_type
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,   // [2:0] server_index, [18:3] server_load, zero
  output logic                  m_tuser,   // [0] newly_picked
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IDX_W = APB_ADDR_W - 2;

  weight_t    weight [NUM_WREGS];
  logic [IDX_W-1:0] reg_idx;
  logic       cfg_wr;

  logic       s1_valid;
  logic       s1_type;
  client_t    s1_client;
  logic       s1_advance;
  logic       accept;
  logic       pick;
  server_t    server_sel;

  server_t    out_server;
  logic       out_picked;
  load_t      out_load;

  pick_ctl_t  pick_ctl;
  pick_res_t  pick_res;
  map_wr_t    map_wr;
  map_rd_t    map_rd;

  // Configuration: weights, written on the access phase
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WREGS; i++) weight[i] <= WEIGHT_RESET[i];
    end else if (cfg_wr) begin
      for (int i = 0; i < NUM_WREGS; i++) begin
        if (reg_idx == IDX_W'(i)) weight[i] <= pwdata[WEIGHT_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    for (int i = 0; i < NUM_WREGS; i++) begin
      if (reg_idx == IDX_W'(i)) prdata = {{(APB_DATA_W-WEIGHT_W){1'b0}}, weight[i]};
    end
  end

  // Handshake: advance the work stage whenever the result register frees up
  assign s1_advance = s1_valid && (!m_tvalid || m_tready);
  assign s_tready   = !s1_valid || s1_advance;
  assign accept     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_type   <= s_tuser;
      s1_client <= s_tdata;
    end
  end

  // Client map: read on acceptance, written when a picked request leaves
  assign map_wr.en     = s1_advance && pick;
  assign map_wr.client = s1_client;
  assign map_wr.server = pick_res.winner;

  swrr_map #(
    .NUM_CLIENTS (NUM_CLIENTS)
  ) u_map (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_client (s_tdata),
    .lk_client (s1_client),
    .wr        (map_wr),
    .rd        (map_rd)
  );

  // Reuse the mapping only for a service request with a valid entry
  assign pick       = !((s1_type == REQ_SERVICE) && map_rd.hit);
  assign server_sel = pick ? pick_res.winner : map_rd.server;

  assign pick_ctl.pick   = pick;
  assign pick_ctl.commit = s1_advance;
  assign pick_ctl.server = map_rd.server;

  swrr_pick #(
    .NUM_SERVERS (NUM_SERVERS)
  ) u_pick (
    .clk    (clk),
    .rst    (rst),
    .weight (weight),
    .ctl    (pick_ctl),
    .res    (pick_res)
  );

  // Result register: hold until the downstream takes the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_server <= server_sel;
      out_picked <= pick;
      out_load   <= pick_res.load;
    end
  end

  assign m_tdata = {5'b0, out_load, out_server};
  assign m_tuser = out_picked;

  `SWRR_ASSERT_SAME(a_no_overrun, clk, rst, accept && s1_valid, s1_advance)
  `SWRR_ASSERT_NEXT(a_stall_keeps, clk, rst, s1_valid && m_tvalid && !m_tready, s1_valid)
  `SWRR_ASSERT_SAME(a_pick_loads, clk, rst, m_tvalid && m_tuser, out_load != '0)
  `SWRR_ASSERT_SAME(a_server_range, clk, rst, m_tvalid, 32'(out_server) < NUM_SERVERS)

endmodule
